// ----- sv/pee_pkg.sv -----
// shared types, symbol codes and the microcode program of the postfix evaluator
package pee_pkg;

  // status codes of a result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // ascii symbols
  localparam logic [7:0] SYM_ZERO = 8'd48;
  localparam logic [7:0] SYM_NINE = 8'd57;
  localparam logic [7:0] SYM_POW  = 8'h5e;
  localparam logic [7:0] SYM_MUL  = 8'h2a;
  localparam logic [7:0] SYM_DIV  = 8'h2f;
  localparam logic [7:0] SYM_ADD  = 8'h2b;
  localparam logic [7:0] SYM_SUB  = 8'h2d;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_NO_IN,
    C_ERR,
    C_DIGIT,
    C_LT2,
    C_BUSY,
    C_DIVZ,
    C_NOPUSH,
    C_FULL,
    C_NOT_LAST,
    C_OUT_FULL
  } cond_e;

  typedef enum logic {
    RD_TOP,
    RD_SECOND
  } rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_DIGIT,
    WR_RESULT
  } wr_e;

  typedef enum logic [2:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC1,
    SP_DEC2,
    SP_CLEAR
  } sp_e;

  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t S_FETCH  = 5'd0;
  localparam step_t S_CHKERR = 5'd1;
  localparam step_t S_CHKDIG = 5'd2;
  localparam step_t S_CHKLT2 = 5'd3;
  localparam step_t S_RDTOP  = 5'd4;
  localparam step_t S_RDSEC  = 5'd5;
  localparam step_t S_START  = 5'd6;
  localparam step_t S_WAIT   = 5'd7;
  localparam step_t S_CHKDZ  = 5'd8;
  localparam step_t S_CHKNP  = 5'd9;
  localparam step_t S_PUSH   = 5'd10;
  localparam step_t S_POP2   = 5'd11;
  localparam step_t S_UND    = 5'd12;
  localparam step_t S_DZ     = 5'd13;
  localparam step_t S_DIG    = 5'd14;
  localparam step_t S_WRDIG  = 5'd15;
  localparam step_t S_OVR    = 5'd16;
  localparam step_t S_END    = 5'd17;
  localparam step_t S_OWAIT  = 5'd18;
  localparam step_t S_RDOUT  = 5'd19;
  localparam step_t S_EMIT   = 5'd20;

  typedef struct packed {
    cond_e      cond;
    step_t      target;
    logic       accept;
    rd_e        rd;
    logic       ld_right;
    logic       alu_start;
    wr_e        wr;
    sp_e        sp;
    logic [1:0] err_set;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic err;
    logic digit;
    logic lt2;
    logic full;
    logic alu_busy;
    logic divz;
    logic nopush;
    logic not_last;
    logic out_full;
  } stat_t;

  function automatic ctrl_t ucode(input step_t addr);
    ctrl_t c;
    c.cond      = C_NEXT;
    c.target    = S_FETCH;
    c.accept    = 1'b0;
    c.rd        = RD_TOP;
    c.ld_right  = 1'b0;
    c.alu_start = 1'b0;
    c.wr        = WR_NONE;
    c.sp        = SP_HOLD;
    c.err_set   = ST_OK;
    c.emit      = 1'b0;
    case (addr)
      S_FETCH: begin
        c.accept = 1'b1;
        c.cond   = C_NO_IN;
        c.target = S_FETCH;
      end
      S_CHKERR: begin
        c.cond   = C_ERR;
        c.target = S_END;
      end
      S_CHKDIG: begin
        c.cond   = C_DIGIT;
        c.target = S_DIG;
      end
      S_CHKLT2: begin
        c.cond   = C_LT2;
        c.target = S_UND;
      end
      S_RDTOP: begin
        c.rd = RD_TOP;
      end
      S_RDSEC: begin
        c.rd       = RD_SECOND;
        c.ld_right = 1'b1;
      end
      S_START: begin
        c.alu_start = 1'b1;
      end
      S_WAIT: begin
        c.cond   = C_BUSY;
        c.target = S_WAIT;
      end
      S_CHKDZ: begin
        c.cond   = C_DIVZ;
        c.target = S_DZ;
      end
      S_CHKNP: begin
        c.cond   = C_NOPUSH;
        c.target = S_POP2;
      end
      S_PUSH: begin
        c.wr     = WR_RESULT;
        c.sp     = SP_DEC1;
        c.cond   = C_JUMP;
        c.target = S_END;
      end
      S_POP2: begin
        c.sp     = SP_DEC2;
        c.cond   = C_JUMP;
        c.target = S_END;
      end
      S_UND: begin
        c.err_set = ST_UNDER;
        c.cond    = C_JUMP;
        c.target  = S_END;
      end
      S_DZ: begin
        c.err_set = ST_DIVZ;
        c.cond    = C_JUMP;
        c.target  = S_END;
      end
      S_DIG: begin
        c.cond   = C_FULL;
        c.target = S_OVR;
      end
      S_WRDIG: begin
        c.wr     = WR_DIGIT;
        c.sp     = SP_INC;
        c.cond   = C_JUMP;
        c.target = S_END;
      end
      S_OVR: begin
        c.err_set = ST_OVER;
        c.cond    = C_JUMP;
        c.target  = S_END;
      end
      S_END: begin
        c.cond   = C_NOT_LAST;
        c.target = S_FETCH;
      end
      S_OWAIT: begin
        c.cond   = C_OUT_FULL;
        c.target = S_OWAIT;
      end
      S_RDOUT: begin
        c.rd = RD_TOP;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.sp     = SP_CLEAR;
        c.cond   = C_JUMP;
        c.target = S_FETCH;
      end
      default: begin
        c.cond   = C_JUMP;
        c.target = S_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- sv/postfix_expression_evaluator_unit.sv -----
// top level of the postfix expression evaluator
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   symbol_i, last_i
//   out      output     out_valid_o / out_stall_i value_o, status_o
//
// a digit is pushed on the stack; + - * and other symbols take two operands
// divide works one quotient bit a cycle, power by repeated multiply and square
// (multiply and square share one multiplier); the last word adds the output steps
// after reset the stack is empty; the stack memory itself is not cleared
// in_stall_o is low only while waiting for a word; a result waits in the
// output register and blocks a further result only while out_stall_i holds
module postfix_expression_evaluator_unit
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  ctrl_t       ctrl;
  stat_t       stat;

  logic [7:0]  sym_q;
  logic        last_q;
  logic [SP_W-1:0] sp_q;
  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;
  logic [1:0]  err_q;
  logic [31:0] right_q;
  logic        out_valid_q;
  logic [31:0] value_q;
  logic [1:0]  status_q;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0] ram_rdata;

  alu_op_e     alu_op;
  logic        alu_busy;
  logic        alu_divz;
  logic [31:0] alu_result;
  logic        is_digit;
  logic [7:0]  digit_val;

  assign sp_m1     = sp_q - SP_W'(1);
  assign sp_m2     = sp_q - SP_W'(2);
  assign is_digit  = (sym_q >= SYM_ZERO) && (sym_q <= SYM_NINE);
  assign digit_val = sym_q - SYM_ZERO;

  always_comb begin
    case (sym_q)
      SYM_POW: alu_op = OP_POW;
      SYM_MUL: alu_op = OP_MUL;
      SYM_DIV: alu_op = OP_DIV;
      SYM_ADD: alu_op = OP_ADD;
      SYM_SUB: alu_op = OP_SUB;
      default: alu_op = OP_NONE;
    endcase
  end

  always_comb begin
    stat.in_valid = in_valid_i;
    stat.err      = (err_q != ST_OK);
    stat.digit    = is_digit;
    stat.lt2      = (sp_q < SP_W'(2));
    stat.full     = (sp_q >= SP_W'(STACK_DEPTH));
    stat.alu_busy = alu_busy;
    stat.divz     = alu_divz;
    stat.nopush   = (alu_op == OP_NONE);
    stat.not_last = !last_q;
    stat.out_full = out_valid_q && out_stall_i;
  end

  pee_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // stack memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sp_q[AW-1:0];
    ram_wdata = {24'd0, digit_val};
    case (ctrl.wr)
      WR_DIGIT: begin
        ram_we = 1'b1;
      end
      WR_RESULT: begin
        ram_we    = 1'b1;
        ram_waddr = sp_m2[AW-1:0];
        ram_wdata = alu_result;
      end
      default: ram_we = 1'b0;
    endcase
    ram_raddr = (ctrl.rd == RD_SECOND) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
  end

  pee_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // left operand comes straight from the memory read in the start step
  pee_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl.alu_start),
    .op_i     (alu_op),
    .a_i      (ram_rdata),
    .b_i      (right_q),
    .busy_o   (alu_busy),
    .divz_o   (alu_divz),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q       <= '0;
      last_q      <= 1'b0;
      sp_q        <= '0;
      err_q       <= ST_OK;
      right_q     <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      status_q    <= ST_OK;
    end else begin
      if (ctrl.accept && in_valid_i) begin
        sym_q  <= symbol_i;
        last_q <= last_i;
      end
      if (ctrl.ld_right) begin
        right_q <= ram_rdata;
      end
      case (ctrl.sp)
        SP_INC:   sp_q <= sp_q + SP_W'(1);
        SP_DEC1:  sp_q <= sp_m1;
        SP_DEC2:  sp_q <= sp_m2;
        SP_CLEAR: sp_q <= '0;
        default:  sp_q <= sp_q;
      endcase
      if (ctrl.emit) begin
        err_q <= ST_OK;
      end else if (ctrl.err_set != ST_OK) begin
        err_q <= ctrl.err_set;
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
        if (err_q != ST_OK) begin
          value_q  <= '0;
          status_q <= err_q;
        end else if (sp_q == '0) begin
          value_q  <= '0;
          status_q <= ST_UNDER;
        end else begin
          value_q  <= ram_rdata;
          status_q <= ST_OK;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = !ctrl.accept;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !alu_busy)
    else $error("word accepted while arithmetic unit busy");

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (value_o == 32'd0))
    else $error("nonzero value with error status");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> ((sp_q == '0) && (err_q == ST_OK) && out_valid_o))
    else $error("stack or error not cleared after result");

endmodule

// ----- sv/pee_ram.sv -----
// generic single-port-write ram with registered read
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pee_alu.sv -----
// arithmetic unit: add, subtract, multiply, iterative divide and power
module pee_alu
  import pee_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  alu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        busy_o,
  output logic        divz_o,
  output logic [31:0] result_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_DIVFIX,
    A_POWMUL,
    A_POWSQR
  } alu_state_e;

  alu_state_e  state_q;
  logic [31:0] res_q;
  logic        divz_q;
  logic [31:0] acc_q;
  logic [31:0] base_q;
  logic [31:0] exp_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic        neg_q;
  logic [4:0]  cnt_q;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [31:0] prod;
  logic [32:0] sh;
  logic [32:0] diff;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  // one shared multiplier, operands picked by state
  always_comb begin
    case (state_q)
      A_POWMUL: begin
        mul_x = acc_q;
        mul_y = base_q;
      end
      A_POWSQR: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      default: begin
        mul_x = a_i;
        mul_y = b_i;
      end
    endcase
  end

  assign prod  = mul_x * mul_y;
  assign sh    = {rem_q, quo_q[31]};
  assign diff  = sh - {1'b0, den_q};
  assign mag_a = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mag_b = b_i[31] ? (32'd0 - b_i) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      res_q   <= '0;
      divz_q  <= 1'b0;
      acc_q   <= '0;
      base_q  <= '0;
      exp_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      den_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            divz_q <= 1'b0;
            case (op_i)
              OP_ADD: res_q <= a_i + b_i;
              OP_SUB: res_q <= a_i - b_i;
              OP_MUL: res_q <= prod;
              OP_DIV: begin
                if (b_i == 32'd0) begin
                  divz_q <= 1'b1;
                end else begin
                  rem_q   <= '0;
                  quo_q   <= mag_a;
                  den_q   <= mag_b;
                  neg_q   <= a_i[31] ^ b_i[31];
                  cnt_q   <= '0;
                  state_q <= A_DIV;
                end
              end
              OP_POW: begin
                if (b_i[31]) begin
                  // negative exponent: only unit bases survive
                  if (a_i == 32'd0) begin
                    divz_q <= 1'b1;
                  end else if (a_i == 32'd1) begin
                    res_q <= 32'd1;
                  end else if (a_i == 32'hffff_ffff) begin
                    res_q <= b_i[0] ? 32'hffff_ffff : 32'd1;
                  end else begin
                    res_q <= 32'd0;
                  end
                end else begin
                  acc_q   <= 32'd1;
                  base_q  <= a_i;
                  exp_q   <= b_i;
                  state_q <= A_POWMUL;
                end
              end
              default: res_q <= res_q;
            endcase
          end
        end
        A_DIV: begin
          if (!diff[32]) begin
            rem_q <= diff[31:0];
          end else begin
            rem_q <= sh[31:0];
          end
          quo_q <= {quo_q[30:0], !diff[32]};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= A_DIVFIX;
          end
        end
        A_DIVFIX: begin
          res_q   <= neg_q ? (32'd0 - quo_q) : quo_q;
          state_q <= A_IDLE;
        end
        A_POWMUL: begin
          if (exp_q == 32'd0) begin
            res_q   <= acc_q;
            state_q <= A_IDLE;
          end else begin
            if (exp_q[0]) begin
              acc_q <= prod;
            end
            state_q <= A_POWSQR;
          end
        end
        A_POWSQR: begin
          base_q  <= prod;
          exp_q   <= {1'b0, exp_q[31:1]};
          state_q <= A_POWMUL;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != A_IDLE);
  assign divz_o   = divz_q;
  assign result_o = res_q;

endmodule

// ----- sv/pee_seq.sv -----
// microcode sequencer: step counter, program rom and conditional jumps
module pee_seq
  import pee_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t pc_q;
  step_t pc_d;
  ctrl_t ctrl;
  logic  taken;

  assign ctrl = ucode(pc_q);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     taken = 1'b0;
      C_JUMP:     taken = 1'b1;
      C_NO_IN:    taken = !stat_i.in_valid;
      C_ERR:      taken = stat_i.err;
      C_DIGIT:    taken = stat_i.digit;
      C_LT2:      taken = stat_i.lt2;
      C_BUSY:     taken = stat_i.alu_busy;
      C_DIVZ:     taken = stat_i.divz;
      C_NOPUSH:   taken = stat_i.nopush;
      C_FULL:     taken = stat_i.full;
      C_NOT_LAST: taken = stat_i.not_last;
      C_OUT_FULL: taken = stat_i.out_full;
      default:    taken = 1'b1;
    endcase
    pc_d = taken ? ctrl.target : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule
